/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/alts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package alts_pkg;

  localparam int FRAC_W      = 16;  // 16.16 coordinates
  localparam int BYTE_W      = 8;
  localparam int SHADE_SHIFT = 8;
  localparam int TBL_IDX_W   = 16;  // widest table index
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [2:0] {
    OP_TEXEL_WR   = 3'd0,
    OP_LOW_WR     = 3'd1,
    OP_HIGH_WR    = 3'd2,
    OP_SPAN_START = 3'd3,
    OP_DRAW       = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_S_STEP     = 3'd0,
    CFG_T_STEP     = 3'd1,
    CFG_LIGHT_STEP = 3'd2,
    CFG_S_OFFSET   = 3'd3,
    CFG_T_OFFSET   = 3'd4,
    CFG_WIDTH_LOG2 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                 en;
    logic                 high;
    logic [TBL_IDX_W-1:0] addr;
    logic [15:0]          data;
  } tbl_wr_t;

  typedef struct packed {
    logic                 en;
    logic [TBL_IDX_W-1:0] lo_idx;
    logic [TBL_IDX_W-1:0] hi_idx;
  } tbl_rd_t;

endpackage

`default_nettype wire

/* rtl/alts_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface alts_span_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [15:0]        address;
  logic [15:0]        data;
  logic signed [31:0] s_start;
  logic signed [31:0] t_start;
  logic signed [31:0] light_start;
  logic [15:0]        span_width;

  modport source (output valid, operation, address, data, s_start, t_start,
                  light_start, span_width, input ready);
  modport sink (input valid, operation, address, data, s_start, t_start,
                light_start, span_width, output ready);
endinterface

interface alts_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic        last_in_span;

  modport source (output valid, pixel, last_in_span, input ready);
  modport sink (input valid, pixel, last_in_span, output ready);
endinterface

interface alts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/alts_tables.sv */
`timescale 1ns / 1ps
`default_nettype none

// Low-byte and high-byte colour tables: one write port shared, one read each.
module alts_tables
  import alts_pkg::*;
#(
  parameter int TABLE_WORDS = 8192
) (
  input  wire logic    clk,
  input  wire tbl_wr_t wr,
  input  wire tbl_rd_t rd,
  output logic [15:0]  lo,
  output logic [15:0]  hi
);

  localparam int AW = $clog2(TABLE_WORDS);

  logic [15:0] low_mem  [TABLE_WORDS];
  logic [15:0] high_mem [TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.high) begin
      low_mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      lo <= low_mem[rd.lo_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.high) begin
      high_mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      hi <= high_mem[rd.hi_idx[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

/* rtl/affine_lit_texture_span.sv */
// Affine lit texture span unit.
// items (sink): one word per operation - texel write, low/high colour table
//   write, span start, draw. Writes and span starts produce nothing.
// pixels (source): one word per draw while the span has pixels left,
//   carrying the lit 16-bit pixel and a flag on the span's final pixel.
// cfg (sink): register writes (steps, start offsets, texture row log2),
//   always ready; write only while no item is in flight.
// Pipeline: accept (texel read, coordinate step) -> table read -> output
//   register. A draw word passes stage 1 and stage 2 to the output register,
//   then shows on pixels. One word per cycle is sustained while pixels is
//   ready, the rate set by each store's single read port, used once per draw.
// Table writes travel down the pipe and land at the table read stage, so
// they stay ordered against draws still in flight.
// Stall: stages hold when pixels is not ready; items stays ready until the
//   table read stage itself is blocked, so up to two more draws (and any
//   other words between them) enter while a finished pixel waits.
// Reset (rst, synchronous): clears pipeline valids, coordinates, pixel count
//   and registers (row log2 back to 8). The stores are not cleared and read
//   undefined until written; there is no clearing pass.
// Store depths must be powers of two; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module affine_lit_texture_span
  import alts_pkg::*;
#(
  parameter int TEXTURE_WORDS = 65536,
  parameter int SHADE_MASK    = 31,
  parameter int TABLE_WORDS   = 8192
) (
  input wire logic     clk,
  input wire logic     rst,
  alts_cfg_if.sink     cfg,
  alts_span_if.sink    items,
  alts_pixel_if.source pixels
);

  localparam int TEX_AW = $clog2(TEXTURE_WORDS);
  localparam logic [15:0] SHADE_FIELD = 16'(SHADE_MASK) << SHADE_SHIFT;

  // config registers
  logic [31:0] s_step, t_step, light_step, s_offset, t_offset;
  logic [4:0]  width_log2;

  // span state
  logic [31:0] s_pos, t_pos, light;
  logic [15:0] pixels_left;

  // texture store
  logic [15:0] tex_mem [TEXTURE_WORDS];
  logic [15:0] texel_q;

  // stage 1: texel read done, table op pending
  logic        s1_valid;
  op_t         s1_op;
  logic [15:0] s1_shade, s1_addr, s1_data;
  logic        s1_last;

  // stage 2: table data registered
  logic        s2_valid, s2_last;
  logic [15:0] lo_q, hi_q;

  // output register
  logic        out_valid, out_last;
  logic [15:0] out_pixel;

  logic        accept, draw_live, s1_enters;
  logic        out_free, s2_go, s2_free, s1_go, s1_free;
  op_t         op;
  logic [31:0] s_int, t_int, tex_sum;
  logic [TEX_AW-1:0] tex_raddr;
  logic [16:0] lo_sum, hi_sum;
  tbl_wr_t     tbl_wr;
  tbl_rd_t     tbl_rd;

  // ---- handshake and stage flow ----
  always_comb begin
    out_free  = !out_valid || pixels.ready;
    s2_go     = s2_valid && out_free;
    s2_free   = !s2_valid || s2_go;
    s1_go     = s1_valid && ((s1_op != OP_DRAW) || s2_free);
    s1_free   = !s1_valid || s1_go;
    accept    = items.valid && s1_free;
    op        = op_t'(items.operation);
    draw_live = pixels_left != 16'd0;
    s1_enters = accept && (((op == OP_DRAW) && draw_live) ||
                           (op == OP_LOW_WR) || (op == OP_HIGH_WR));
  end

  assign items.ready = s1_free;
  assign cfg.ready   = 1'b1;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s_step     <= '0;
      t_step     <= '0;
      light_step <= '0;
      s_offset   <= '0;
      t_offset   <= '0;
      width_log2 <= 5'd8;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_S_STEP:     s_step     <= cfg.data;
        CFG_T_STEP:     t_step     <= cfg.data;
        CFG_LIGHT_STEP: light_step <= cfg.data;
        CFG_S_OFFSET:   s_offset   <= cfg.data;
        CFG_T_OFFSET:   t_offset   <= cfg.data;
        CFG_WIDTH_LOG2: width_log2 <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // ---- coordinate accumulators ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s_pos       <= '0;
      t_pos       <= '0;
      light       <= '0;
      pixels_left <= '0;
    end else if (accept) begin
      case (op)
        OP_SPAN_START: begin
          s_pos       <= items.s_start + s_offset;
          t_pos       <= items.t_start + t_offset;
          light       <= items.light_start;
          pixels_left <= items.span_width;
        end
        OP_DRAW: begin
          if (draw_live) begin
            s_pos       <= s_pos + s_step;
            t_pos       <= t_pos + t_step;
            light       <= light + light_step;
            pixels_left <= pixels_left - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // texel address: integer parts, sign-extended, row shift, wrap at depth
  always_comb begin
    s_int     = {{FRAC_W{s_pos[31]}}, s_pos[31:FRAC_W]};
    t_int     = {{FRAC_W{t_pos[31]}}, t_pos[31:FRAC_W]};
    tex_sum   = s_int + (t_int << width_log2);
    tex_raddr = tex_sum[TEX_AW-1:0];
  end

  // ---- texture store: write and read both at accept, in item order ----
  always_ff @(posedge clk) begin
    if (accept && (op == OP_TEXEL_WR)) begin
      tex_mem[TEX_AW'(items.address)] <= items.data;
    end
    if (accept && (op == OP_DRAW) && draw_live) begin
      texel_q <= tex_mem[tex_raddr];
    end
  end

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s1_enters;
    end
    if (accept) begin
      s1_op    <= op;
      s1_shade <= light[15:0] & SHADE_FIELD;
      s1_last  <= pixels_left == 16'd1;
      s1_addr  <= items.address;
      s1_data  <= items.data;
    end
  end

  always_comb begin
    lo_sum        = 17'(s1_shade) + 17'(texel_q[BYTE_W-1:0]);
    hi_sum        = 17'(s1_shade) + 17'(texel_q[15:BYTE_W]);
    tbl_wr.en     = s1_go && ((s1_op == OP_LOW_WR) || (s1_op == OP_HIGH_WR));
    tbl_wr.high   = s1_op == OP_HIGH_WR;
    tbl_wr.addr   = s1_addr;
    tbl_wr.data   = s1_data;
    tbl_rd.en     = s1_go && (s1_op == OP_DRAW);
    tbl_rd.lo_idx = lo_sum[TBL_IDX_W-1:0];
    tbl_rd.hi_idx = hi_sum[TBL_IDX_W-1:0];
  end

  alts_tables #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_tables (
    .clk (clk),
    .wr  (tbl_wr),
    .rd  (tbl_rd),
    .lo  (lo_q),
    .hi  (hi_q)
  );

  // ---- stage 2 ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= tbl_rd.en;
    end
    if (tbl_rd.en) begin
      s2_last <= s1_last;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_go;
    end
    if (s2_go) begin
      out_pixel <= lo_q + hi_q;
      out_last  <= s2_last;
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.pixel        = out_pixel;
  assign pixels.last_in_span = out_last;

  // ---- checks ----
  `ASSERT_NXT(a_span_load, clk, rst, accept && (op == OP_SPAN_START),
              pixels_left == $past(items.span_width), "span count not loaded")
  `ASSERT_NXT(a_count_step, clk, rst, accept && (op == OP_DRAW) && draw_live,
              pixels_left == $past(pixels_left) - 16'd1, "pixel count not stepped")
  `ASSERT_NXT(a_draw_reaches_s2, clk, rst, tbl_rd.en, s2_valid,
              "table read lost before stage 2")
  `ASSERT_IMP(a_stall_cause, clk, rst, !items.ready, s1_valid && !s1_go,
              "input blocked without a held stage 1")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the lit affine span texturer.
// A scoreboard model tracks the texture store, both colour tables, the span
// accumulators and the register set; every accepted draw word that has pixels
// left pushes the expected pixel, and a checker process pops one per accepted
// output word. Draws are always preceded by whatever writes are needed so the
// block never reads a store entry that was never loaded.
module testbench;
  import alts_pkg::*;

  localparam int TEX_WORDS    = 65536;
  localparam int SHADE        = 31;
  localparam int TBL_WORDS    = 8192;
  localparam int IDLE_PCT     = 35;
  localparam int DRAIN_CYCLES = 8;      // pipe is 3 deep, allow some slack
  localparam int MAX_SHOWN    = 10;
  localparam int TIMEOUT_NS   = 2_000_000;

  // operation codes the block must ignore
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] address;
    logic [15:0] data;
    logic [31:0] s_start;
    logic [31:0] t_start;
    logic [31:0] light_start;
    logic [15:0] span_width;
  } span_item_t;

  typedef struct {
    logic [15:0] pixel;
    logic        last_in_span;
  } pixel_word_t;

  typedef struct {
    logic [31:0] s_step;
    logic [31:0] t_step;
    logic [31:0] light_step;
    logic [31:0] s_offset;
    logic [31:0] t_offset;
    logic [4:0]  width_log2;
  } span_settings_t;

  logic clk;
  logic rst;

  alts_cfg_if   cfg ();
  alts_span_if  items ();
  alts_pixel_if pixels ();

  affine_lit_texture_span #(
    .TEXTURE_WORDS(TEX_WORDS),
    .SHADE_MASK   (SHADE),
    .TABLE_WORDS  (TBL_WORDS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .items (items),
    .pixels(pixels)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Scoreboard model state
  // ---------------------------------------------------------------------
  logic [15:0]    texture_img [TEX_WORDS];
  bit             texture_set [TEX_WORDS];
  logic [15:0]    low_tbl     [TBL_WORDS];
  bit             low_set     [TBL_WORDS];
  logic [15:0]    high_tbl    [TBL_WORDS];
  bit             high_set    [TBL_WORDS];
  logic [31:0]    s_pos;
  logic [31:0]    t_pos;
  logic [31:0]    light_pos;
  logic [15:0]    pix_left;
  span_settings_t span_cfg;

  pixel_word_t pending_pixels[$];  // expected pixels, oldest first

  // shared knobs between the stimulus and the pixel checker
  bit calm;            // no random idling on either side while set
  int stall_budget;    // cycles the pixel side holds ready low
  int useful_items;    // accepted words that were not ignored
  int fail_count;

  // integer part of a 16.16 value, sign extended
  function automatic logic [31:0] whole_part(logic [31:0] v);
    return {{FRAC_W{v[31]}}, v[31:FRAC_W]};
  endfunction

  function automatic int texel_index();
    logic [31:0] sum;
    sum = whole_part(s_pos) + (whole_part(t_pos) << span_cfg.width_log2);
    return int'(sum % TEX_WORDS);
  endfunction

  function automatic int table_slot(logic [7:0] texel_byte);
    logic [31:0] shade;
    shade = light_pos & (32'(SHADE) << SHADE_SHIFT);
    return int'((shade + 32'(texel_byte)) % TBL_WORDS);
  endfunction

  // Model update for one accepted word. Returns 1 unless the word is ignored.
  function automatic bit apply_span_item(span_item_t it);
    int          ta;
    logic [15:0] texel;
    pixel_word_t w;
    case (it.op)
      OP_TEXEL_WR: begin
        texture_img[it.address % TEX_WORDS] = it.data;
        texture_set[it.address % TEX_WORDS] = 1'b1;
        return 1'b1;
      end
      OP_LOW_WR: begin
        low_tbl[it.address % TBL_WORDS] = it.data;
        low_set[it.address % TBL_WORDS] = 1'b1;
        return 1'b1;
      end
      OP_HIGH_WR: begin
        high_tbl[it.address % TBL_WORDS] = it.data;
        high_set[it.address % TBL_WORDS] = 1'b1;
        return 1'b1;
      end
      OP_SPAN_START: begin
        s_pos     = it.s_start + span_cfg.s_offset;
        t_pos     = it.t_start + span_cfg.t_offset;
        light_pos = it.light_start;
        pix_left  = it.span_width;
        return 1'b1;
      end
      OP_DRAW: begin
        if (pix_left == 16'd0) return 1'b0;
        ta = texel_index();
        texel = texture_img[ta];
        w.pixel = low_tbl[table_slot(texel[BYTE_W-1:0])] +
                  high_tbl[table_slot(texel[15:BYTE_W])];
        w.last_in_span = (pix_left == 16'd1);
        pending_pixels.push_back(w);
        s_pos     += span_cfg.s_step;
        t_pos     += span_cfg.t_step;
        light_pos += span_cfg.light_step;
        pix_left--;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  function automatic span_item_t random_item();
    span_item_t it;
    it.op          = OP_DRAW;
    it.address     = 16'($urandom);
    it.data        = 16'($urandom);
    it.s_start     = $urandom;
    it.t_start     = $urandom;
    it.light_start = $urandom;
    it.span_width  = 16'($urandom);
    return it;
  endfunction

  // Offers one word and returns right after the edge that takes it.
  // valid is left high so back-to-back words need no re-raise.
  task automatic send_item(input span_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    end
    items.valid       <= 1'b1;
    items.operation   <= it.op;
    items.address     <= it.address;
    items.data        <= it.data;
    items.s_start     <= it.s_start;
    items.t_start     <= it.t_start;
    items.light_start <= it.light_start;
    items.span_width  <= it.span_width;
    @(posedge clk);
    while (items.ready !== 1'b1) @(posedge clk);
    if (apply_span_item(it)) useful_items++;
  endtask

  task automatic items_idle();
    items.valid <= 1'b0;
  endtask

  // Sender pause: wait out every pending pixel plus the pipe depth, since
  // table writes and empty draws may still be in flight with nothing owed.
  task automatic wait_drained();
    items_idle();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_store(input logic [2:0] op, input logic [15:0] addr,
                             input logic [15:0] value);
    span_item_t it;
    it = random_item();
    it.op      = op;
    it.address = addr;
    it.data    = value;
    send_item(it);
  endtask

  // Load any texel or table entry the next draw will read but that was
  // never written - those reads are undefined in the block.
  task automatic prime_draw_reads();
    int          ta;
    int          slot;
    logic [15:0] texel;
    if (pix_left == 16'd0) return;
    ta = texel_index();
    if (!texture_set[ta]) write_store(OP_TEXEL_WR, ta[15:0], 16'($urandom));
    texel = texture_img[ta];
    slot = table_slot(texel[BYTE_W-1:0]);
    if (!low_set[slot]) write_store(OP_LOW_WR, slot[15:0], 16'($urandom));
    slot = table_slot(texel[15:BYTE_W]);
    if (!high_set[slot]) write_store(OP_HIGH_WR, slot[15:0], 16'($urandom));
  endtask

  task automatic draw_pixel();
    span_item_t it;
    it = random_item();
    it.op = OP_DRAW;
    prime_draw_reads();
    send_item(it);
  endtask

  task automatic start_span(input logic [31:0] s, input logic [31:0] t,
                            input logic [31:0] light, input logic [15:0] width);
    span_item_t it;
    it = random_item();
    it.op          = OP_SPAN_START;
    it.s_start     = s;
    it.t_start     = t;
    it.light_start = light;
    it.span_width  = width;
    send_item(it);
  endtask

  task automatic load_random();
    logic [2:0] op;
    case ($urandom_range(2))
      0:       op = OP_TEXEL_WR;
      1:       op = OP_LOW_WR;
      default: op = OP_HIGH_WR;
    endcase
    write_store(op, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_reserved();
    span_item_t it;
    it = random_item();
    case ($urandom_range(2))
      0:       it.op = OP_RSVD5;
      1:       it.op = OP_RSVD6;
      default: it.op = OP_RSVD7;
    endcase
    send_item(it);
  endtask

  // Register port: valid stays high across a burst of writes.
  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_S_STEP:     span_cfg.s_step     = value;
      CFG_T_STEP:     span_cfg.t_step     = value;
      CFG_LIGHT_STEP: span_cfg.light_step = value;
      CFG_S_OFFSET:   span_cfg.s_offset   = value;
      CFG_T_OFFSET:   span_cfg.t_offset   = value;
      CFG_WIDTH_LOG2: span_cfg.width_log2 = value[4:0];
      default: ;
    endcase
  endtask

  // Writes all six registers; with_spare also pokes the unused indexes,
  // which must not disturb anything.
  task automatic load_settings(input span_settings_t c, input bit with_spare);
    if (with_spare) begin
      cfg_word(CFG_RSVD6, $urandom);
      cfg_word(CFG_RSVD7, $urandom);
    end
    cfg_word(CFG_S_STEP, c.s_step);
    cfg_word(CFG_T_STEP, c.t_step);
    cfg_word(CFG_LIGHT_STEP, c.light_step);
    cfg_word(CFG_S_OFFSET, c.s_offset);
    cfg_word(CFG_T_OFFSET, c.t_offset);
    cfg_word(CFG_WIDTH_LOG2, {27'd0, c.width_log2});
    cfg.valid <= 1'b0;
  endtask

  // gentle: small steps so neighbouring pixels hit nearby texels and shades
  function automatic span_settings_t random_settings(bit gentle);
    span_settings_t c;
    if (gentle) begin
      c.s_step     = $urandom_range(32'h3FFFF) - 32'h20000;
      c.t_step     = $urandom_range(32'h3FFFF) - 32'h20000;
      c.light_step = $urandom_range(32'h3FF) - 32'h200;
    end else begin
      c.s_step     = $urandom;
      c.t_step     = $urandom;
      c.light_step = $urandom;
    end
    c.s_offset   = $urandom;
    c.t_offset   = $urandom;
    c.width_log2 = 5'($urandom_range(16));
    return c;
  endfunction

  // One chunk of random traffic, mostly complete spans.
  task automatic random_burst();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 70) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      start_span($urandom, $urandom, $urandom, n[15:0]);
      if ($urandom_range(4) == 0) n++;  // one draw past the end
      repeat (n) begin
        if ($urandom_range(9) == 0) load_random();
        draw_pixel();
      end
    end else if (pick < 82) begin
      load_random();
    end else if (pick < 90) begin
      send_reserved();
    end else if (pick < 96) begin
      // span cut short by the next start; full 16-bit width
      start_span($urandom, $urandom, $urandom, 16'($urandom));
      repeat ($urandom_range(1, 3)) draw_pixel();
    end else begin
      start_span($urandom, $urandom, $urandom, 16'd0);
      draw_pixel();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every operation, wrapping writes, ignored codes,
  // empty draws and sign extension of the coordinates.
  task automatic test_directed_ops();
    write_store(OP_TEXEL_WR, 16'h0000, 16'h0000);
    write_store(OP_TEXEL_WR, 16'hFFFF, 16'hFFFF);
    write_store(OP_LOW_WR, 16'hFFFF, 16'hFFFF);   // wraps to top entry
    write_store(OP_HIGH_WR, 16'h2000, 16'h8001);  // wraps to entry 0
    write_store(OP_LOW_WR, 16'h0000, 16'h7FFF);
    send_item('{OP_RSVD5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 16'hFFFF});
    send_item('{OP_RSVD6, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 16'h0});
    send_reserved();
    draw_pixel();                                 // nothing left after reset
    start_span(32'h0, 32'h0, 32'h0, 16'd1);
    draw_pixel();                                 // single pixel, last set
    draw_pixel();                                 // past the end
    start_span(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'd3);
    repeat (3) draw_pixel();
    start_span(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    repeat (2) draw_pixel();
    start_span($urandom, $urandom, $urandom, 16'd0);
    draw_pixel();
  endtask

  task automatic test_config_extremes();
    wait_drained();
    load_settings('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 5'd16}, 1'b1);
    start_span($urandom, $urandom, $urandom, 16'd4);
    repeat (4) draw_pixel();
    wait_drained();
    load_settings('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd0}, 1'b0);
    start_span($urandom, $urandom, $urandom, 16'd4);
    repeat (4) draw_pixel();
  endtask

  // Long stretch with both sides always willing.
  task automatic test_full_rate();
    int goal;
    wait_drained();
    load_settings(random_settings(1'b1), 1'b0);
    calm = 1'b1;
    goal = useful_items + 100;
    while (useful_items < goal) random_burst();
    calm = 1'b0;
  endtask

  // Pixel side holds off while draws keep coming: the pipe fills and the
  // item side must stall. Then the sender waits for everything to drain.
  task automatic test_backpressure();
    calm = 1'b1;
    stall_budget = 200;
    start_span($urandom, $urandom, $urandom, 16'd32);
    repeat (32) draw_pixel();
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    int goal;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      load_settings(random_settings(phase % 2 == 0), phase == 1);
      goal = useful_items + 60;
      while (useful_items < goal) random_burst();
    end
  endtask

  // ---------------------------------------------------------------------
  // Pixel checker and ready generator
  // ---------------------------------------------------------------------
  initial begin : pixel_checker
    pixel_word_t want;
    pixels.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // values seen here are the ones the edge sampled
      if (rst === 1'b0 && pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
        if (pending_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected pixel: got pixel %h last %b",
                     pixels.pixel, pixels.last_in_span);
        end else begin
          want = pending_pixels.pop_front();
          if (pixels.pixel !== want.pixel ||
              pixels.last_in_span !== want.last_in_span) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("pixel mismatch: expected pixel %h last %b, got pixel %h last %b",
                       want.pixel, want.last_in_span, pixels.pixel,
                       pixels.last_in_span);
          end
        end
      end
      if (stall_budget > 0) begin
        pixels.ready <= 1'b0;
        stall_budget--;
      end else begin
        pixels.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[affine_lit_texture_span] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    rst               <= 1'b1;
    cfg.valid         <= 1'b0;
    cfg.index         <= '0;
    cfg.data          <= '0;
    items.valid       <= 1'b0;
    items.operation   <= '0;
    items.address     <= '0;
    items.data        <= '0;
    items.s_start     <= '0;
    items.t_start     <= '0;
    items.light_start <= '0;
    items.span_width  <= '0;
    calm         = 1'b0;
    stall_budget = 0;
    useful_items = 0;
    fail_count   = 0;
    s_pos        = '0;
    t_pos        = '0;
    light_pos    = '0;
    pix_left     = '0;
    span_cfg     = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd8};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_config_extremes();
    test_full_rate();
    test_backpressure();
    test_random_phases();

    items_idle();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[affine_lit_texture_span] OK");
    end else begin
      $display("[affine_lit_texture_span] ERROR");
    end
    $finish;
  end

endmodule

/* affine_lit_texture_span.f */
+incdir+rtl
rtl/alts_pkg.sv
rtl/alts_ifs.sv
rtl/alts_tables.sv
rtl/affine_lit_texture_span.sv
verif/testbench.sv
